// File: design/ilid_pkg.sv
// Package: widths, operation and status codes, and controller/datapath types of the list unit.
package ilid_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = 12;
  localparam int DATA_W   = 32;
  localparam int FUNC_W   = 3;
  localparam int STAT_W   = 2;
  localparam int CMP_W    = (CNT_W > IDX_W - 1) ? CNT_W : IDX_W - 1;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [IDX_W-1:0]  index_t;
  typedef logic [FUNC_W-1:0]        func_t;
  typedef logic [STAT_W-1:0]        status_t;
  typedef logic [CNT_W-1:0]         count_t;

  localparam func_t FN_GET      = 3'd0;
  localparam func_t FN_INS_HEAD = 3'd1;
  localparam func_t FN_INS_TAIL = 3'd2;
  localparam func_t FN_INS_AT   = 3'd3;
  localparam func_t FN_DEL      = 3'd4;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  localparam word_t NEG_ONE = '1;

  typedef enum logic [1:0] {
    K_ERR = 2'd0,
    K_GET = 2'd1,
    K_INS = 2'd2,
    K_DEL = 2'd3
  } kind_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic get_rd;
    logic step;
    logic put;
    logic dec;
    logic emit;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  direct;
    logic  last_rd;
    logic  shift_up;
    logic  out_free;
  } stat_t;

endpackage

// File: design/ilid_if.sv
// Interfaces: request and result channels of the list unit.
interface ilid_in_if;
  import ilid_pkg::*;
  logic   valid;
  logic   ready;
  func_t  func;
  index_t index;
  word_t  value;
  modport source (output valid, output func, output index, output value, input ready);
  modport sink (input valid, input func, input index, input value, output ready);
endinterface

interface ilid_out_if;
  import ilid_pkg::*;
  logic    valid;
  logic    ready;
  word_t   read_value;
  status_t status;
  count_t  list_length;
  modport source (output valid, output read_value, output status, output list_length,
                  input ready);
  modport sink (input valid, input read_value, input status, input list_length,
                output ready);
endinterface

// File: design/ilid_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ilid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/ilid_dp.sv
// Datapath: request registers, length counter, shift engine, entry store and result register.
module ilid_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  ilid_pkg::cmd_t   cmd,
  output ilid_pkg::stat_t  stat,
  input  ilid_pkg::func_t  in_func,
  input  ilid_pkg::index_t in_index,
  input  ilid_pkg::word_t  in_value,
  input  logic             out_ready,
  output logic             out_valid,
  output ilid_pkg::word_t  out_read_value,
  output ilid_pkg::status_t out_status,
  output ilid_pkg::count_t out_list_length
);
  import ilid_pkg::*;

  func_t   func_r;
  index_t  idx_r;
  word_t   val_r;
  count_t  count_r, count_nxt;
  kind_t   kind_r, kind_w;
  status_t st_r, st_w;
  logic [ADDR_W-1:0] pos_r, rd_ptr_r, end_r, src_r;
  logic              dir_up_r, pend_r;
  logic              out_valid_r;
  word_t             out_rd_r;
  status_t           out_st_r;
  count_t            out_len_r;

  logic [CMP_W-1:0]  idx_mag, cnt_ext, pos_w;
  logic              idx_neg, in_range, full;
  logic              ram_wr_en, ram_rd_en;
  logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
  word_t             ram_wr_data, ram_rd_data;

  assign idx_neg  = idx_r[IDX_W-1];
  assign idx_mag  = CMP_W'(idx_r[IDX_W-2:0]);
  assign cnt_ext  = CMP_W'(count_r);
  assign in_range = !idx_neg && (idx_mag < cnt_ext);
  assign full     = (count_r == CNT_W'(CAPACITY));

  always_comb begin
    kind_w = K_ERR;
    st_w   = ST_RANGE;
    pos_w  = '0;
    case (func_r)
      FN_GET: begin
        if (in_range) begin
          kind_w = K_GET;
          st_w   = ST_DONE;
        end
      end
      FN_INS_HEAD: begin
        kind_w = K_INS;
      end
      FN_INS_TAIL: begin
        kind_w = K_INS;
        pos_w  = cnt_ext;
      end
      FN_INS_AT: begin
        if (idx_neg) begin
          kind_w = K_INS;
        end else if (idx_mag <= cnt_ext) begin
          kind_w = K_INS;
          pos_w  = idx_mag;
        end
      end
      FN_DEL: begin
        if (in_range) begin
          kind_w = K_DEL;
          pos_w  = idx_mag;
        end
      end
      default: begin
        kind_w = K_ERR;
      end
    endcase
    if (kind_w == K_INS) begin
      if (full) begin
        kind_w = K_ERR;
        st_w   = ST_FULL;
      end else begin
        st_w = ST_DONE;
      end
    end else if (kind_w == K_DEL) begin
      st_w = ST_DONE;
    end
  end

  assign stat.kind     = kind_w;
  assign stat.direct   = (kind_w == K_INS) ? (pos_w == cnt_ext)
                                           : (pos_w + CMP_W'(1) == cnt_ext);
  assign stat.last_rd  = (rd_ptr_r == end_r);
  assign stat.shift_up = dir_up_r;
  assign stat.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      idx_r  <= in_index;
      val_r  <= in_value;
    end
    if (cmd.eval) begin
      kind_r <= kind_w;
      st_r   <= st_w;
      pos_r  <= ADDR_W'(pos_w);
      if (kind_w == K_INS) begin
        dir_up_r <= 1'b1;
        rd_ptr_r <= ADDR_W'(cnt_ext - CMP_W'(1));
        end_r    <= ADDR_W'(pos_w);
      end else begin
        dir_up_r <= 1'b0;
        rd_ptr_r <= ADDR_W'(pos_w + CMP_W'(1));
        end_r    <= ADDR_W'(cnt_ext - CMP_W'(1));
      end
    end
    if (cmd.step) begin
      rd_ptr_r <= dir_up_r ? rd_ptr_r - ADDR_W'(1) : rd_ptr_r + ADDR_W'(1);
      src_r    <= rd_ptr_r;
    end
    if (cmd.emit) begin
      out_rd_r  <= (kind_r == K_GET) ? ram_rd_data : NEG_ONE;
      out_st_r  <= st_r;
      out_len_r <= count_r;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.put) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      pend_r  <= cmd.step;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign ram_rd_en   = cmd.get_rd | cmd.step;
  assign ram_rd_addr = cmd.get_rd ? ADDR_W'(idx_mag) : rd_ptr_r;
  assign ram_wr_en   = pend_r | cmd.put;
  assign ram_wr_addr = cmd.put ? pos_r
                     : (dir_up_r ? src_r + ADDR_W'(1) : src_r - ADDR_W'(1));
  assign ram_wr_data = cmd.put ? val_r : ram_rd_data;

  ilid_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_rd_r;
  assign out_status      = out_st_r;
  assign out_list_length = out_len_r;

  // The length never exceeds the capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("list length above capacity");

  // A shifted word and the new value never compete for the write port.
  a_wr_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(pend_r && cmd.put))
    else $error("write port conflict");

  // An insert is only committed while there is room.
  a_put_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.put |-> !full)
    else $error("insert into a full list");

endmodule

// File: design/ilid_ctrl.sv
// Controller: state machine that sequences decode, read, shift, insert and result hand-off.
module ilid_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ilid_pkg::stat_t stat,
  output ilid_pkg::cmd_t  cmd
);
  import ilid_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EVAL  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_SHIFT = 7'b0001000,
    S_DRAIN = 7'b0010000,
    S_PUT   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        case (stat.kind)
          K_GET: begin
            cmd.get_rd = 1'b1;
            state_nxt  = S_READ;
          end
          K_INS: begin
            state_nxt = stat.direct ? S_PUT : S_SHIFT;
          end
          K_DEL: begin
            if (stat.direct) begin
              cmd.dec   = 1'b1;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_SHIFT;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_READ: begin
        state_nxt = S_DONE;
      end
      S_SHIFT: begin
        cmd.step = 1'b1;
        if (stat.last_rd) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (stat.shift_up) begin
          state_nxt = S_PUT;
        end else begin
          cmd.dec   = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A shift run always ends in the drain step.
  a_shift_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && stat.last_rd) |=> (state_r == S_DRAIN))
    else $error("shift run did not drain");

  // A result is handed over only once per accepted word.
  a_emit_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (state_r == S_IDLE) && !cmd.emit)
    else $error("result handed over twice");

  // A get always reads the store before its result is formed.
  a_get_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.get_rd |=> (state_r == S_READ))
    else $error("get did not wait for read data");

endmodule

// File: design/indexed_list_insert_delete_unit.sv
// Top level of the indexed list unit.
// Holds an ordered list of up to CAPACITY signed 32-bit words in a single-port-write RAM and
// returns one result word per request word. A get reads the addressed entry from the RAM. An
// insert or delete moves each later entry by one place through the RAM, one entry per cycle with
// read and write overlapped, and an insert then writes the new word; a request that moves no
// entry skips the shift. The worst case is an insert at the head of a list one short of full;
// the RAM's single write port sets it. Rejected requests go straight to the result step.
// While an earlier result still waits on the output, the unit holds in its last step. A new
// request word is taken in the cycle after the previous result has been registered, even while
// that result still waits on the output.
// The stored entries are not cleared at reset; only the length is, so no clearing pass is needed.
module indexed_list_insert_delete_unit (
  input logic       clk,
  input logic       rst_n,
  ilid_in_if.sink   in_ch,
  ilid_out_if.source out_ch
);
  import ilid_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ilid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ilid_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_func         (in_ch.func),
    .in_index        (in_ch.index),
    .in_value        (in_ch.value),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_read_value  (out_ch.read_value),
    .out_status      (out_ch.status),
    .out_list_length (out_ch.list_length)
  );

  // A full status is reported only with the list at capacity.
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_FULL) |-> (out_ch.list_length == CNT_W'(CAPACITY)))
    else $error("full status with room left");

  // Any failed request returns minus one.
  a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ST_DONE) |-> (out_ch.read_value == NEG_ONE))
    else $error("failed request returned a value");

  // No status code beyond full is ever produced.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.status == ST_DONE || out_ch.status == ST_RANGE ||
                      out_ch.status == ST_FULL))
    else $error("undefined status code");

endmodule
